// File: design/rrts_pkg.sv
// shared constants, codes and types of the round robin task scheduler
// no dependencies; imported by rrts_alu and round_robin_task_scheduler
package rrts_pkg;

    localparam int NUM_TASKS = 4;
    localparam int NUM_SEMS  = 2;

    localparam int TASK_W = $clog2(NUM_TASKS + 1);
    localparam int TIDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int SEM_IW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int WAIT_W = $clog2(NUM_SEMS + 1);
    localparam int TICK_W = 32;
    localparam int CMD_W  = 2;

    localparam logic [TASK_W-1:0] IDLE_TASK = TASK_W'(NUM_TASKS);
    localparam logic [TASK_W-1:0] LAST_TASK = TASK_W'(NUM_TASKS - 1);
    localparam logic [WAIT_W-1:0] NOT_WAITING = '0;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SLEEP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TAKE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_GIVE  = 2'd3;

    typedef struct packed {
        logic [TICK_W-1:0] dec;
        logic              zero;
    } alu_res_t;

endpackage

// File: design/rrts_alu.sv
// shared counter unit: decrement and zero test of one sleep counter
// depends on rrts_pkg
module rrts_alu
    import rrts_pkg::*;
(
    input  logic [TICK_W-1:0] operand,
    output alu_res_t          res
);

    assign res.zero = (operand == '0);
    assign res.dec  = operand - TICK_W'(1);

endmodule

// File: design/round_robin_task_scheduler.sv
// top level of the round robin task scheduler: sequencer, task table, output register
// depends on rrts_pkg and rrts_alu
//
// usage
//   input channel: command, sleep_ticks and semaphore_id move on a transfer
//   (in_valid high, in_stall low). in_stall is high while an event is being
//   worked on, so one event is handled at a time.
//   output channel: running_task, switched and rejected move on a transfer
//   (out_valid high, out_stall low); one result per event.
// sequencing
//   the sequencer walks the task entries one per clock through a single
//   counter unit (decrement and zero test). a tick is accepted, decrements
//   every nonzero sleep counter, runs the round robin search and finishes;
//   sleep and blocking take are accepted, search and finish; give is
//   accepted, scans the waiters and finishes; an event that needs no
//   search is accepted and finishes.
// reset
//   all sleep counters and wait marks clear, semaphores unavailable, task 0
//   running, no result pending.
// stall
//   a finished result waits in the output register; a held result blocks
//   only the finish step of the next event, which waits until it is taken.
module round_robin_task_scheduler
    import rrts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CMD_W-1:0]   command,
    input  logic [TICK_W-1:0]  sleep_ticks,
    input  logic               semaphore_id,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [TASK_W-1:0]  running_task,
    output logic               switched,
    output logic               rejected
);

    // sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TICK  = 3'd1;
    localparam logic [2:0] ST_SCHED = 3'd2;
    localparam logic [2:0] ST_GIVE  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // round robin successor, wrapping after the idle task
    function automatic logic [TASK_W-1:0] next_task(input logic [TASK_W-1:0] t);
        next_task = (t >= IDLE_TASK) ? '0 : t + TASK_W'(1);
    endfunction

    logic [2:0]        state_reg, state_next;
    logic [TASK_W-1:0] idx_reg, idx_next;
    logic [TASK_W-1:0] cur_reg, cur_next;
    logic [TASK_W-1:0] before_reg, before_next;
    logic              sem_reg, sem_next;
    logic              rej_reg, rej_next;

    logic [TICK_W-1:0] sleep_left_reg [NUM_TASKS];
    logic [TICK_W-1:0] sleep_left_next [NUM_TASKS];
    logic [WAIT_W-1:0] waiting_on_reg [NUM_TASKS];
    logic [WAIT_W-1:0] waiting_on_next [NUM_TASKS];
    logic [NUM_SEMS-1:0] sem_av_reg, sem_av_next;

    logic              out_valid_reg, out_valid_next;
    logic [TASK_W-1:0] running_task_reg, running_task_next;
    logic              switched_reg, switched_next;
    logic              rejected_reg, rejected_next;

    logic [TIDX_W-1:0] rd_idx;
    logic [TIDX_W-1:0] cur_idx;
    logic              idx_is_task;
    logic              cand_ready;
    logic              cur_is_idle;
    logic              sem_ok_in;
    logic [WAIT_W-1:0] wait_code_in;
    logic [WAIT_W-1:0] wait_code_reg;
    logic              in_xfer;
    alu_res_t          alu_res;

    // the one counter unit, fed from the entry under the walk index
    rrts_alu u_alu (
        .operand (sleep_left_reg[rd_idx]),
        .res     (alu_res)
    );

    assign rd_idx        = idx_reg[TIDX_W-1:0];
    assign cur_idx       = cur_reg[TIDX_W-1:0];
    assign idx_is_task   = (idx_reg < IDLE_TASK);
    assign cand_ready    = !idx_is_task
                           || (alu_res.zero && waiting_on_reg[rd_idx] == NOT_WAITING);
    assign cur_is_idle   = (cur_reg >= IDLE_TASK);
    assign sem_ok_in     = (int'(semaphore_id) < NUM_SEMS);
    assign wait_code_in  = WAIT_W'(semaphore_id) + WAIT_W'(1);
    assign wait_code_reg = WAIT_W'(sem_reg) + WAIT_W'(1);

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        cur_next          = cur_reg;
        before_next       = before_reg;
        sem_next          = sem_reg;
        rej_next          = rej_reg;
        sleep_left_next   = sleep_left_reg;
        waiting_on_next   = waiting_on_reg;
        sem_av_next       = sem_av_reg;
        out_valid_next    = out_valid_reg && out_stall;
        running_task_next = running_task_reg;
        switched_next     = switched_reg;
        rejected_next     = rejected_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    before_next = cur_reg;
                    sem_next    = semaphore_id;
                    rej_next    = 1'b0;
                    idx_next    = next_task(cur_reg);
                    state_next  = ST_DONE;
                    case (command)
                        CMD_TICK:
                        begin
                            idx_next   = '0;
                            state_next = ST_TICK;
                        end
                        CMD_SLEEP:
                        begin
                            if (cur_is_idle && sleep_ticks != '0)
                            begin
                                rej_next = 1'b1;
                            end
                            else
                            begin
                                if (!cur_is_idle)
                                begin
                                    sleep_left_next[cur_idx] = sleep_ticks;
                                end
                                state_next = ST_SCHED;
                            end
                        end
                        CMD_TAKE:
                        begin
                            if (sem_ok_in)
                            begin
                                if (sem_av_reg[SEM_IW'(semaphore_id)])
                                begin
                                    sem_av_next[SEM_IW'(semaphore_id)] = 1'b0;
                                end
                                else if (cur_is_idle)
                                begin
                                    rej_next = 1'b1;
                                end
                                else
                                begin
                                    waiting_on_next[cur_idx] = wait_code_in;
                                    state_next = ST_SCHED;
                                end
                            end
                        end
                        CMD_GIVE:
                        begin
                            if (sem_ok_in)
                            begin
                                idx_next   = '0;
                                state_next = ST_GIVE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            // one counter per cycle through the shared decrementer
            ST_TICK:
            begin
                if (!alu_res.zero)
                begin
                    sleep_left_next[rd_idx] = alu_res.dec;
                end
                if (idx_reg == LAST_TASK)
                begin
                    idx_next   = next_task(cur_reg);
                    state_next = ST_SCHED;
                end
                else
                begin
                    idx_next = idx_reg + TASK_W'(1);
                end
            end
            // one candidate per cycle; the idle task always ends the search
            ST_SCHED:
            begin
                if (cand_ready)
                begin
                    cur_next   = idx_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = next_task(idx_reg);
                end
            end
            // lowest-numbered waiter on the semaphore wins; with no waiter the semaphore becomes available
            ST_GIVE:
            begin
                if (waiting_on_reg[rd_idx] == wait_code_reg)
                begin
                    waiting_on_next[rd_idx] = NOT_WAITING;
                    cur_next   = idx_reg;
                    state_next = ST_DONE;
                end
                else if (idx_reg == LAST_TASK)
                begin
                    sem_av_next[SEM_IW'(sem_reg)] = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + TASK_W'(1);
                end
            end
            // wait for the output register to be free
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    running_task_next = cur_reg;
                    switched_next     = (cur_reg != before_reg);
                    rejected_next     = rej_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            sem_av_reg    <= '0;
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                sleep_left_reg[i] <= '0;
                waiting_on_reg[i] <= NOT_WAITING;
            end
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            cur_reg         <= cur_next;
            out_valid_reg   <= out_valid_next;
            sem_av_reg      <= sem_av_next;
            sleep_left_reg  <= sleep_left_next;
            waiting_on_reg  <= waiting_on_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        before_reg       <= before_next;
        sem_reg          <= sem_next;
        rej_reg          <= rej_next;
        running_task_reg <= running_task_next;
        switched_reg     <= switched_next;
        rejected_reg     <= rejected_next;
    end

    assign out_valid    = out_valid_reg;
    assign running_task = running_task_reg;
    assign switched     = switched_reg;
    assign rejected     = rejected_reg;

endmodule
